### design/ps16_pkg.sv
`default_nettype none

package ps16_pkg;

  // sample format codes
  localparam logic [2:0] FMT_U8   = 3'd0;
  localparam logic [2:0] FMT_S16  = 3'd1;
  localparam logic [2:0] FMT_S24  = 3'd2;
  localparam logic [2:0] FMT_S32  = 3'd3;
  localparam logic [2:0] FMT_ALAW = 3'd4;
  localparam logic [2:0] FMT_ULAW = 3'd5;

  // configuration register indexes
  localparam logic CFG_IDX_FORMAT = 1'b0;
  localparam logic CFG_IDX_STEREO = 1'b1;

  localparam logic [2:0] FORMAT_RESET = FMT_S16;
  localparam logic       STEREO_RESET = 1'b1;

  localparam int unsigned CfgDataW = 3;

  localparam logic [7:0] SIGN_FLIP = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               right_channel;
  } out_beat_t;

  // one completed stereo frame
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } frame_t;

  // G.711 A-law expansion
  function automatic logic [15:0] alaw_expand(input logic [7:0] code);
    logic [7:0]  a;
    logic [2:0]  seg;
    logic [14:0] mag;
    a   = code ^ 8'h55;
    seg = a[6:4];
    if (seg == 3'd0) begin
      mag = {7'd0, a[3:0], 4'h8};
    end else begin
      mag = 15'({a[3:0], 4'h0} + 9'h108) << (seg - 3'd1);
    end
    if (a[7]) begin
      alaw_expand = {1'b0, mag};
    end else begin
      alaw_expand = 16'd0 - {1'b0, mag};
    end
  endfunction

  // G.711 mu-law expansion
  function automatic logic [15:0] ulaw_expand(input logic [7:0] code);
    logic [7:0]  u;
    logic [14:0] mag;
    u   = ~code;
    mag = 15'({1'b0, u[3:0], 3'b000} + 8'h84) << u[6:4];
    if (u[7]) begin
      ulaw_expand = 16'h0084 - {1'b0, mag};
    end else begin
      ulaw_expand = {1'b0, mag} - 16'h0084;
    end
  endfunction

endpackage

`default_nettype wire

### design/pcm_to_s16_stereo_converter_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         push / full          in_i  : data_byte, end_of_data
// results   out        empty / pop          out_o : sample, right_channel
// config    in         cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle while the frame queue has room; the front end
// assembles, expands and pairs samples in the cycle a byte is accepted.
// Each finished frame leaves as two result beats, left then right, one per
// cycle while pop is asserted and frames are queued.
// Reset clears the stream position, the held left sample and all queues;
// sample_format comes up as signed 16 and stereo_mode as interleaved.
// full rises only when both queue slots hold frames not yet started.

module pcm_to_s16_stereo_converter_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output      logic                full,
  input  wire ps16_pkg::in_beat_t  in_i,
  output      logic                empty,
  input  wire logic                pop,
  output      ps16_pkg::out_beat_t out_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [ps16_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic             accept;
  logic             frame_vld;
  ps16_pkg::frame_t frame;
  ps16_pkg::frame_t q_frame;
  logic             q_rd;
  logic             q_avail;

  // a byte beat is taken whenever the frame queue can absorb a frame
  assign accept = push && !full;

  ps16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_i        (in_i),
    .frame_vld_o (frame_vld),
    .frame_o     (frame)
  );

  // short queue decoupling byte intake from beat output
  ps16_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (frame_vld),
    .wdata_i (frame),
    .rd_i    (q_rd),
    .rdata_o (q_frame),
    .full_o  (full),
    .avail_o (q_avail)
  );

  ps16_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (q_avail),
    .frame_i (q_frame),
    .rd_o    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### design/ps16_front.sv
`default_nettype none

module ps16_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [ps16_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic              accept_i,
  input  wire ps16_pkg::in_beat_t in_i,
  output      logic              frame_vld_o,
  output      ps16_pkg::frame_t  frame_o
);

  logic [2:0]  fmt_q;
  logic        stereo_q;
  logic [1:0]  pos_q, pos_d;
  logic [15:0] asm_q, asm_d;
  logic [15:0] held_q, held_d;
  logic        held_vld_q, held_vld_d;

  logic        fmt_ok;
  logic [1:0]  last_pos;
  logic        done;
  logic [15:0] smp;
  logic [15:0] asm_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= ps16_pkg::FORMAT_RESET;
      stereo_q <= ps16_pkg::STEREO_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ps16_pkg::CFG_IDX_FORMAT: fmt_q    <= cfg_wdata_i[2:0];
        ps16_pkg::CFG_IDX_STEREO: stereo_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fmt_ok = (fmt_q <= ps16_pkg::FMT_ULAW);
    case (fmt_q)
      ps16_pkg::FMT_S16: last_pos = 2'd1;
      ps16_pkg::FMT_S24: last_pos = 2'd2;
      ps16_pkg::FMT_S32: last_pos = 2'd3;
      default:           last_pos = 2'd0;
    endcase
    asm_nxt = {in_i.data_byte, asm_q[15:8]};
    done    = fmt_ok && (pos_q >= last_pos);
    case (fmt_q)
      ps16_pkg::FMT_U8:   smp = {in_i.data_byte ^ ps16_pkg::SIGN_FLIP, 8'h00};
      ps16_pkg::FMT_ALAW: smp = ps16_pkg::alaw_expand(in_i.data_byte);
      ps16_pkg::FMT_ULAW: smp = ps16_pkg::ulaw_expand(in_i.data_byte);
      default:            smp = asm_nxt;
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    asm_d       = asm_q;
    held_d      = held_q;
    held_vld_d  = held_vld_q;
    frame_vld_o = 1'b0;
    frame_o.left  = stereo_q ? held_q : smp;
    frame_o.right = smp;
    if (accept_i) begin
      if (fmt_ok) begin
        asm_d = asm_nxt;
        pos_d = done ? 2'd0 : pos_q + 2'd1;
      end
      if (done) begin
        if (!stereo_q) begin
          held_vld_d  = 1'b0;
          frame_vld_o = 1'b1;
        end else if (!held_vld_q) begin
          held_d     = smp;
          held_vld_d = 1'b1;
        end else begin
          held_vld_d  = 1'b0;
          frame_vld_o = 1'b1;
        end
      end
      // end of chunk drops any partial sample or unpaired left
      if (in_i.end_of_data) begin
        pos_d      = 2'd0;
        asm_d      = 16'd0;
        held_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 2'd0;
      asm_q      <= 16'd0;
      held_q     <= 16'd0;
      held_vld_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      asm_q      <= asm_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
    end
  end

endmodule

`default_nettype wire

### design/ps16_fifo.sv
`default_nettype none

module ps16_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire ps16_pkg::frame_t wdata_i,
  input  wire logic             rd_i,
  output      ps16_pkg::frame_t rdata_o,
  output      logic             full_o,
  output      logic             avail_o
);

  ps16_pkg::frame_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/ps16_back.sv
`default_nettype none

module ps16_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                avail_i,
  input  wire ps16_pkg::frame_t    frame_i,
  output      logic                rd_o,
  output      logic                empty,
  input  wire logic                pop,
  output      ps16_pkg::out_beat_t out_o
);

  ps16_pkg::frame_t frame_q;
  logic vld_q;
  logic right_q;
  logic taken;

  assign empty = ~vld_q;
  assign taken = pop && vld_q;
  // refill when idle or when the right beat leaves
  assign rd_o  = avail_i && (!vld_q || (taken && right_q));

  assign out_o.sample        = right_q ? frame_q.right : frame_q.left;
  assign out_o.right_channel = right_q;

  always_ff @(posedge clk_i) begin
    if (rd_o) begin
      frame_q <= frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      right_q <= 1'b0;
    end else if (rd_o) begin
      vld_q   <= 1'b1;
      right_q <= 1'b0;
    end else if (taken) begin
      if (right_q) begin
        vld_q   <= 1'b0;
        right_q <= 1'b0;
      end else begin
        right_q <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
